>>> src/fasp_pkg.sv
package fasp_pkg;

  // event kinds
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_COMMIT  = 2'd1;
  localparam logic [1:0] MODE_SUCCESS = 2'd2;
  localparam logic [1:0] MODE_REINIT  = 2'd3;

  // result actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // register indexes
  localparam logic CFG_OUTAGE_THRESH = 1'b0;
  localparam logic CFG_SUCCESS_GRACE = 1'b1;

  // register reset values
  localparam logic [31:0] OUTAGE_THRESH_RST = 32'd30000;
  localparam logic [31:0] SUCCESS_GRACE_RST = 32'd5000;

  localparam int TimeW = 63;
  localparam int GenW  = 32;

  typedef logic [TimeW-1:0] time_ms_t;
  typedef logic [GenW-1:0]  gen_t;

  // one input word
  typedef struct packed {
    logic [1:0] mode;
    time_ms_t   now_time_ms;
    gen_t       generation;
    logic       config_ok;
    logic       usb_start_request;
    logic       link_up;
  } item_t;

  // policy state; a time with its never flag set stands for "never"
  typedef struct packed {
    logic     running;
    logic     ap_start_never;
    time_ms_t ap_start_time;
    gen_t     ap_start_gen;
    gen_t     success_gen;
    logic     success_never;
    time_ms_t success_time;
    time_ms_t outage_start_time;
  } policy_state_t;

  // state after reset or reinitialize, with the outage timer starting at boot
  function automatic policy_state_t cleared_state(time_ms_t boot);
    policy_state_t s;
    s.running           = 1'b0;
    s.ap_start_never    = 1'b1;
    s.ap_start_time     = '0;
    s.ap_start_gen      = '0;
    s.success_gen       = '0;
    s.success_never     = 1'b1;
    s.success_time      = '0;
    s.outage_start_time = boot;
    return s;
  endfunction

  // true when the reference time exists, now is not earlier, and dur has elapsed
  function automatic logic aged(time_ms_t now, logic rt_never, time_ms_t rt,
                                logic [31:0] dur);
    logic [TimeW:0] diff;
    diff = {1'b0, now} - {1'b0, rt};
    return !rt_never && !diff[TimeW] && (diff[TimeW-1:0] >= {{(TimeW-32){1'b0}}, dur});
  endfunction

endpackage

>>> src/fasp_if.sv
// input channel
interface fasp_in_if
  import fasp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  time_ms_t   now_time_ms;
  gen_t       generation;
  logic       config_ok;
  logic       usb_start_request;
  logic       link_up;

  modport source (output valid, mode, now_time_ms, generation, config_ok,
                  usb_start_request, link_up, input ready);
  modport sink (input valid, mode, now_time_ms, generation, config_ok,
                usb_start_request, link_up, output ready);
endinterface

// result channel
interface fasp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       ap_running;

  modport source (output valid, action, ap_running, input ready);
  modport sink (input valid, action, ap_running, output ready);
endinterface

>>> src/fasp_policy.sv
module fasp_policy
  import fasp_pkg::*;
(
  input  item_t         item,
  input  policy_state_t cur,
  input  logic [31:0]   outage_thresh,
  input  logic [31:0]   success_grace,
  output policy_state_t nxt,
  output logic [1:0]    action
);

  logic outage_expired;
  logic same_gen;
  logic after_start;
  logic grace_done;

  // outage test uses the old outage start; it only matters with the link down
  assign outage_expired = !item.link_up &&
    aged(item.now_time_ms, 1'b0, cur.outage_start_time, outage_thresh);

  assign same_gen = item.config_ok && (item.generation == cur.ap_start_gen) &&
                    (cur.success_gen == item.generation);

  // never counts as -1, below every real time
  assign after_start = cur.success_never ? cur.ap_start_never :
                       (cur.ap_start_never || (cur.success_time >= cur.ap_start_time));

  assign grace_done = aged(item.now_time_ms, cur.success_never, cur.success_time,
                           success_grace);

  // next state and action per event kind
  always_comb begin
    nxt    = cur;
    action = ACT_NONE;
    case (item.mode)
      MODE_TICK: begin
        if (item.link_up) begin
          nxt.outage_start_time = item.now_time_ms;
        end
        if (!cur.running) begin
          if (!item.config_ok || item.usb_start_request || outage_expired) begin
            nxt.running        = 1'b1;
            nxt.ap_start_never = 1'b0;
            nxt.ap_start_time  = item.now_time_ms;
            nxt.ap_start_gen   = item.generation;
            action             = ACT_START;
          end
        end else if (same_gen && after_start && grace_done) begin
          nxt.running        = 1'b0;
          nxt.ap_start_never = 1'b1;
          nxt.ap_start_time  = '0;
          nxt.ap_start_gen   = '0;
          action             = ACT_STOP;
        end
      end
      MODE_COMMIT: begin
        if (cur.running) begin
          nxt.ap_start_gen = item.generation;
        end
        nxt.success_gen       = '0;
        nxt.success_never     = 1'b1;
        nxt.success_time      = '0;
        nxt.outage_start_time = item.now_time_ms;
      end
      MODE_SUCCESS: begin
        nxt.success_gen       = item.generation;
        nxt.success_never     = 1'b0;
        nxt.success_time      = item.now_time_ms;
        nxt.outage_start_time = item.now_time_ms;
      end
      default: begin
        nxt = cleared_state(item.now_time_ms);
      end
    endcase
  end

endmodule

>>> src/fallback_ap_start_stop_policy.sv
// Fallback access point start/stop policy. Takes one event word per cycle
// while not stalled (tick, config commit, backend success, reinitialize) and
// returns exactly one result word per event: the action taken (none, start,
// stop) and whether the access point runs afterwards. Throughput is one word
// per clock while the result side accepts; an event word is held in the input
// register and its result word is offered from the result register, the two
// registers around the single decision stage, whose longest path is a 63-bit
// time subtract followed by a compare with a 32-bit threshold. Backpressure on
// the result side stalls both registers. The two thresholds (outage start,
// success grace) reset to 30000 and 5000 ms; the user must write them through
// the cfg port only while no event is in flight; the block does not enforce it.
module fallback_ap_start_stop_policy
  import fasp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fasp_in_if.sink     in_ch,
  fasp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]   outage_thresh_r;
  logic [31:0]   success_grace_r;
  item_t         item_r;
  logic          item_valid_r;
  policy_state_t state_r;
  policy_state_t state_nxt;
  logic [1:0]    action_nxt;
  logic [1:0]    action_r;
  logic          running_r;
  logic          out_valid_r;
  logic          advance;

  // result register free or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !item_valid_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outage_thresh_r <= OUTAGE_THRESH_RST;
      success_grace_r <= SUCCESS_GRACE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTAGE_THRESH: outage_thresh_r <= cfg_wdata;
        CFG_SUCCESS_GRACE: success_grace_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.mode              <= in_ch.mode;
      item_r.now_time_ms       <= in_ch.now_time_ms;
      item_r.generation        <= in_ch.generation;
      item_r.config_ok         <= in_ch.config_ok;
      item_r.usb_start_request <= in_ch.usb_start_request;
      item_r.link_up           <= in_ch.link_up;
    end
  end

  // decision logic
  fasp_policy u_policy (
    .item          (item_r),
    .cur           (state_r),
    .outage_thresh (outage_thresh_r),
    .success_grace (success_grace_r),
    .nxt           (state_nxt),
    .action        (action_nxt)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cleared_state('0);
      out_valid_r <= 1'b0;
    end else if (item_valid_r && advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      action_r  <= action_nxt;
      running_r <= state_nxt.running;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.action     = action_r;
  assign out_ch.ap_running = running_r;

endmodule

>>> verif/fallback_ap_start_stop_policy_test.sv
`timescale 1ns / 1ps

module fallback_ap_start_stop_policy_test;
  import fasp_pkg::*;

  typedef struct packed {
    logic [1:0] action;
    logic       ap_running;
  } ap_result_t;

  localparam time_ms_t LATEST_MS = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_OUTAGE_THRESH;
  logic [31:0] cfg_wdata = '0;

  fasp_in_if  in_ch ();
  fasp_out_if out_ch ();

  fallback_ap_start_stop_policy uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // channel drive registers
  logic  in_valid_q = 1'b0;
  item_t in_word_q = '0;
  logic  out_ready_q = 1'b0;

  assign in_ch.valid             = in_valid_q;
  assign in_ch.mode              = in_word_q.mode;
  assign in_ch.now_time_ms       = in_word_q.now_time_ms;
  assign in_ch.generation        = in_word_q.generation;
  assign in_ch.config_ok         = in_word_q.config_ok;
  assign in_ch.usb_start_request = in_word_q.usb_start_request;
  assign in_ch.link_up           = in_word_q.link_up;
  assign out_ch.ready            = out_ready_q;

  item_t      pending_words[$];
  ap_result_t awaited_results[$];
  int         mismatches = 0;

  // policy mirror: times as signed ms, -1 for never
  logic        pol_running;
  longint      pol_start_ms;
  gen_t        pol_start_gen;
  gen_t        pol_ok_gen;
  longint      pol_ok_ms;
  longint      pol_quiet_ms;
  logic [31:0] pol_outage_lim;
  logic [31:0] pol_grace;

  // stimulus tracking of the event stream
  gen_t   gen_cur = '0;
  longint clock_ms = 0;
  longint last_ok_ms = -1;
  longint last_quiet_ms = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint ms(logic [31:0] v);
    return $signed({32'b0, v});
  endfunction

  function automatic bit elapsed(longint now, longint since, logic [31:0] dur);
    return since >= 0 && now >= since && (now - since) >= ms(dur);
  endfunction

  function automatic void clear_policy(longint boot);
    pol_running   = 1'b0;
    pol_start_ms  = -1;
    pol_start_gen = '0;
    pol_ok_gen    = '0;
    pol_ok_ms     = -1;
    pol_quiet_ms  = boot;
  endfunction

  // advance the policy mirror by one event, return the action and run state
  function automatic ap_result_t apply_event(item_t w);
    ap_result_t r;
    longint     now;
    now = $signed({1'b0, w.now_time_ms});
    r.action = ACT_NONE;
    case (w.mode)
      MODE_TICK: begin
        if (w.link_up) pol_quiet_ms = now;
        if (!pol_running) begin
          if (!w.config_ok || w.usb_start_request ||
              (!w.link_up && elapsed(now, pol_quiet_ms, pol_outage_lim))) begin
            pol_running   = 1'b1;
            pol_start_ms  = now;
            pol_start_gen = w.generation;
            r.action      = ACT_START;
          end
        end else if (w.config_ok && w.generation == pol_start_gen &&
                     pol_ok_gen == w.generation && pol_ok_ms >= pol_start_ms &&
                     elapsed(now, pol_ok_ms, pol_grace)) begin
          pol_running   = 1'b0;
          pol_start_ms  = -1;
          pol_start_gen = '0;
          r.action      = ACT_STOP;
        end
      end
      MODE_COMMIT: begin
        if (pol_running) pol_start_gen = w.generation;
        pol_ok_gen   = '0;
        pol_ok_ms    = -1;
        pol_quiet_ms = now;
      end
      MODE_SUCCESS: begin
        pol_ok_gen   = w.generation;
        pol_ok_ms    = now;
        pol_quiet_ms = now;
      end
      default: begin
        clear_policy(now);
      end
    endcase
    r.ap_running = pol_running;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic queue_word(logic [1:0] mode, time_ms_t t, gen_t g,
                            logic ok, logic usb, logic link);
    item_t w;
    w.mode              = mode;
    w.now_time_ms       = t;
    w.generation        = g;
    w.config_ok         = ok;
    w.usb_start_request = usb;
    w.link_up           = link;
    pending_words.push_back(w);
  endtask

  // one random event, mostly a plausible time line with boundary hits
  task automatic queue_random_event();
    int unsigned  pick;
    longint       span;
    item_t        w;
    logic [127:0] raw;
    pick = $urandom_range(0, 99);
    span = ms(pol_outage_lim > pol_grace ? pol_outage_lim : pol_grace) + 1;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(item_t)-1:0];
    if (pick < 8) begin
      pending_words.push_back(w);
      return;
    end
    w.generation = gen_cur;
    if (pick < 13) begin
      w.mode = MODE_REINIT;
      if ($urandom_range(0, 1) == 1) clock_ms = longint'($urandom_range(0, 100000));
      last_quiet_ms = clock_ms;
      last_ok_ms    = -1;
    end else if (pick < 23) begin
      w.mode = MODE_COMMIT;
      case ($urandom_range(0, 2))
        0: gen_cur = gen_cur + 1;
        1: gen_cur = $urandom;
        default: ;
      endcase
      w.generation  = gen_cur;
      last_quiet_ms = clock_ms;
      last_ok_ms    = -1;
    end else if (pick < 43) begin
      w.mode = MODE_SUCCESS;
      clock_ms += longint'($urandom_range(0, 50));
      if ($urandom_range(0, 4) == 0)
        w.generation = gen_cur ^ (32'd1 << $urandom_range(0, 31));
      last_ok_ms    = clock_ms;
      last_quiet_ms = clock_ms;
    end else begin
      w.mode = MODE_TICK;
      case ($urandom_range(0, 5))
        0: if (last_ok_ms >= 0)
             clock_ms = last_ok_ms + ms(pol_grace) + (longint'($urandom_range(0, 2)) - 1);
        1: clock_ms = last_quiet_ms + ms(pol_outage_lim) + (longint'($urandom_range(0, 2)) - 1);
        2: clock_ms = clock_ms - longint'($urandom_range(0, 1000));
        default: clock_ms = clock_ms + (span * longint'($urandom_range(0, 1500))) / 1000;
      endcase
      if (clock_ms < 0 || clock_ms > 64'sh3FFF_FFFF_FFFF_FFFF)
        clock_ms = longint'($urandom_range(0, 100000));
      if ($urandom_range(0, 6) == 0)
        w.generation = gen_cur ^ (32'd1 << $urandom_range(0, 31));
      w.config_ok         = ($urandom_range(0, 6) != 0);
      w.usb_start_request = ($urandom_range(0, 11) == 0);
      w.link_up           = ($urandom_range(0, 2) == 0);
      if (w.link_up) last_quiet_ms = clock_ms;
    end
    w.now_time_ms = clock_ms[62:0];
    pending_words.push_back(w);
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  // sampled away from the rising edge so the drivers have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid_q || awaited_results.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OUTAGE_THRESH) pol_outage_lim = val;
    else pol_grace = val;
  endtask

  task automatic set_limits(logic [31:0] outage_lim, logic [31:0] grace);
    write_reg(CFG_OUTAGE_THRESH, outage_lim);
    write_reg(CFG_SUCCESS_GRACE, grace);
  endtask

  // sender: one word at a time from the pending queue, random gaps
  int unsigned in_gap_left = 0;
  int unsigned in_stretch = 0;
  bit          in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid_q  <= 1'b0;
      in_gap_left <= 0;
    end else begin
      if (in_valid_q && in_ch.ready) awaited_results.push_back(apply_event(in_word_q));
      if (!in_valid_q || in_ch.ready) begin
        if (in_gap_left != 0) begin
          in_valid_q  <= 1'b0;
          in_gap_left <= in_gap_left - 1;
        end else if (pending_words.size() != 0) begin
          in_word_q  <= pending_words.pop_front();
          in_valid_q <= 1'b1;
          if (in_stretch == 0) begin
            in_stretch <= $urandom_range(10, 60);
            in_calm    <= ($urandom_range(0, 2) == 0);
          end else begin
            in_stretch <= in_stretch - 1;
          end
          in_gap_left <= in_calm ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each result word with the oldest prediction
  int unsigned out_wait = 0;
  int unsigned out_stretch = 0;
  bit          out_calm = 1'b0;

  always @(posedge clk) begin
    ap_result_t want;
    int unsigned n;
    if (!rst_n) begin
      out_ready_q <= 1'b0;
      out_wait    <= 0;
    end else if (out_ch.valid && out_ready_q) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result word with no event outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.action !== want.action)
          flag_mismatch($sformatf("action %0d, predicted %0d", out_ch.action, want.action));
        if (out_ch.ap_running !== want.ap_running)
          flag_mismatch($sformatf("ap_running %0b, predicted %0b",
                                  out_ch.ap_running, want.ap_running));
      end
      if (out_stretch == 0) begin
        out_stretch <= $urandom_range(10, 60);
        out_calm    <= ($urandom_range(0, 2) == 0);
      end else begin
        out_stretch <= out_stretch - 1;
      end
      n = out_calm ? 0 : $urandom_range(0, 11);
      out_ready_q <= (n == 0);
      out_wait    <= n;
    end else if (out_wait != 0) begin
      out_wait    <= out_wait - 1;
      out_ready_q <= (out_wait == 1);
    end else begin
      out_ready_q <= 1'b1;
    end
  end

  // hang guard
  initial begin
    #4000000;
    $display("fallback_ap_start_stop_policy_test: done, errors");
    $finish;
  end

  initial begin
    logic [31:0] lim_set[8];
    logic [31:0] grace_set[8];
    clear_policy(0);
    pol_outage_lim = OUTAGE_THRESH_RST;
    pol_grace      = SUCCESS_GRACE_RST;
    lim_set   = '{OUTAGE_THRESH_RST, 32'd0, '1, $urandom_range(0, 500), 32'd1, '1,
                  $urandom, $urandom_range(0, 100000)};
    grace_set = '{SUCCESS_GRACE_RST, 32'd0, '1, $urandom_range(0, 500), '1, 32'd0,
                  $urandom, $urandom_range(0, 20000)};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits: outage edge, stop on grace edge, commit while running
    queue_word(MODE_TICK, 29999, 0, 1, 0, 0);
    queue_word(MODE_TICK, 30000, 7, 1, 0, 0);
    queue_word(MODE_TICK, 30001, 7, 1, 0, 0);
    queue_word(MODE_SUCCESS, 31000, 7, 0, 0, 0);
    queue_word(MODE_TICK, 35999, 7, 1, 0, 0);
    queue_word(MODE_TICK, 36000, 7, 1, 0, 0);
    queue_word(MODE_TICK, 40000, 3, 1, 1, 1);
    queue_word(MODE_COMMIT, 41000, 9, 1, 0, 0);
    queue_word(MODE_SUCCESS, 41500, 9, 0, 1, 1);
    // time going backwards, bad config, wrong generation
    queue_word(MODE_TICK, 41400, 9, 1, 0, 0);
    queue_word(MODE_TICK, 46500, 9, 0, 0, 0);
    queue_word(MODE_TICK, 46500, 8, 1, 0, 0);
    queue_word(MODE_TICK, 46500, 9, 1, 0, 1);
    queue_word(MODE_TICK, 46600, '1, 0, 0, 0);
    // reinit at the latest time, ignored fields all set
    queue_word(MODE_REINIT, LATEST_MS, 32'h5555_5555, 1, 1, 1);
    queue_word(MODE_TICK, LATEST_MS, 0, 1, 0, 0);
    queue_word(MODE_TICK, 0, 0, 1, 0, 0);
    queue_word(MODE_TICK, LATEST_MS, '1, 0, 1, 1);
    queue_word(MODE_SUCCESS, LATEST_MS, '1, 1, 1, 1);
    queue_word(MODE_TICK, LATEST_MS, '1, 1, 0, 0);
    queue_word(MODE_REINIT, 0, 0, 0, 0, 0);
    queue_word(MODE_COMMIT, 5, 0, 0, 1, 1);
    wait_idle();

    // zero limits: start, success and stop in the same ms
    set_limits(32'd0, 32'd0);
    queue_word(MODE_TICK, 5, 32'h2AAA_AAAA, 1, 0, 0);
    queue_word(MODE_SUCCESS, 5, 32'h2AAA_AAAA, 0, 0, 0);
    queue_word(MODE_TICK, 5, 32'h2AAA_AAAA, 1, 0, 0);
    wait_idle();

    // full-scale limits
    set_limits('1, '1);
    queue_word(MODE_REINIT, 0, 0, 0, 0, 0);
    queue_word(MODE_TICK, 63'hFFFF_FFFE, 1, 1, 0, 0);
    queue_word(MODE_TICK, 63'hFFFF_FFFF, 1, 1, 0, 0);

    // random phases, each under its own limits
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      set_limits(lim_set[p], grace_set[p]);
      for (int c = 0; c < 5; c++) begin
        repeat (33) queue_random_event();
        if ($urandom_range(0, 1) == 1) wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("fallback_ap_start_stop_policy_test: done, clean");
    end else begin
      $display("fallback_ap_start_stop_policy_test: done, errors");
    end
    $finish;
  end

endmodule
